// ===== rtl/core/tpe_pkg.sv =====
package tpe_pkg;

  // Node labels and per-node degree counts
  localparam int unsigned LABEL_W    = 6;
  localparam int unsigned DEG_W      = 6;
  localparam int unsigned LABEL_SPAN = 64;

  // Node count register: holds values up to 127, plus the clamp floor
  localparam int unsigned      CNT_W = 7;
  localparam logic [CNT_W-1:0] N_MIN = 7'd2;

  // APB register map
  localparam int unsigned      APB_AW          = 2;
  localparam int unsigned      APB_DW          = 32;
  localparam logic [APB_AW-1:0] ADDR_NODE_COUNT = 2'd0;

  // One node record in the store
  typedef struct packed {
    logic               removed;
    logic [LABEL_W-1:0] nxor;
    logic [DEG_W-1:0]   deg;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_RA,
    S_LD_WA,
    S_LD_RB,
    S_LD_WB,
    S_STEP,
    S_SCAN,
    S_RD_LEAF,
    S_WR_LEAF,
    S_RD_NB,
    S_WR_NB,
    S_EMIT,
    S_DONE
  } state_e;

endpackage

// ===== rtl/core/tpe_store.sv =====
// Node record memory: one write and one registered read per cycle.
// Per-entry valid bits make unwritten entries read as zero; clr_i drops
// them all at once.
module tpe_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  tpe_pkg::entry_t  wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output tpe_pkg::entry_t  rdata_o
);

  tpe_pkg::entry_t mem_q [DEPTH];
  tpe_pkg::entry_t rd_q;
  logic [DEPTH-1:0] valid_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== rtl/core/tree_prufer_encoder.sv =====
// An edge is taken in IDLE, then both endpoint records get a read-modify-write through the
// store; in_stall_o is high outside IDLE. After the last edge each entry runs
// STEP, SCAN (skipped for a leaf found in WR_NB), RD_LEAF, WR_LEAF, RD_NB and WR_NB
// (skipped for a neighbour past the store), then EMIT. The scan pointer only moves forward,
// so a tree's scans read about n addresses. EMIT waits while the output is held; DONE clears
// the store. Reset: asynchronous, active low; store empty, node_count=2.
module tree_prufer_encoder #(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tpe_pkg::APB_AW-1:0]   paddr,
  input  logic [tpe_pkg::APB_DW-1:0]   pwdata,
  output logic [tpe_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,

  // Edge requests
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tpe_pkg::LABEL_W-1:0]  end_a_i,
  input  logic [tpe_pkg::LABEL_W-1:0]  end_b_i,
  input  logic                         last_edge_i,

  // Sequence entries
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tpe_pkg::LABEL_W-1:0]  code_node_o,
  output logic                         last_code_o
);

  // Labels are 6 bits, so no more than 64 nodes are ever addressable.
  localparam int unsigned DEPTH = (MAX_NODES < tpe_pkg::LABEL_SPAN) ?
                                  MAX_NODES : tpe_pkg::LABEL_SPAN;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [tpe_pkg::CNT_W-1:0] DEPTH_C = tpe_pkg::CNT_W'(DEPTH);

  localparam int unsigned LW = tpe_pkg::LABEL_W;
  localparam int unsigned CW = tpe_pkg::CNT_W;

  tpe_pkg::state_e state_q, state_d;

  // Configuration
  logic [CW-1:0] node_count_q;
  logic [CW-1:0] n_eff;
  logic [LW-1:0] total;
  logic          cfg_wr;

  // Request latch
  logic [LW-1:0] a_q, a_d, b_q, b_d;
  logic          last_q, last_d;

  // Encoder sequencing
  logic [LW-1:0] step_q, step_d, step_nx;
  logic [CW-1:0] ptr_q, ptr_d;      // forward scan pointer
  logic [CW-1:0] scan_q, scan_d;    // next address to read during a scan
  logic [LW-1:0] chk_q, chk_d;      // address whose record is on the read port
  logic          chk_vld_q, chk_vld_d;
  logic [LW-1:0] leaf_q, leaf_d;
  logic [LW-1:0] nb_q, nb_d;        // neighbour of the removed leaf
  logic          sc_vld_q, sc_vld_d; // neighbour just became the smallest leaf
  logic [LW-1:0] sc_q, sc_d;

  // Output register
  logic          out_vld_q, out_vld_d;
  logic [LW-1:0] code_q, code_d;
  logic          out_last_q, out_last_d;

  // Store port
  logic            st_we, st_clr;
  logic [AW-1:0]   st_waddr, st_raddr;
  tpe_pkg::entry_t st_wdata, st_rdata;

  // Shared conditions
  logic a_ok, b_ok, nb_ok, rd_nb_ok;
  logic chk_leaf, scan_more, emit_go, step_last, total_zero;
  logic [tpe_pkg::DEG_W-1:0] nb_deg_dec;

  tpe_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (st_clr),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // ---------------------------------------------------------------------------
  // APB: single register, always ready
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == tpe_pkg::ADDR_NODE_COUNT);

  always_comb begin
    prdata = '0;
    if (paddr == tpe_pkg::ADDR_NODE_COUNT) begin
      prdata[CW-1:0] = node_count_q;
    end
  end

  // Effective node count: clamped to 2 .. DEPTH
  always_comb begin
    if (node_count_q < tpe_pkg::N_MIN) begin
      n_eff = tpe_pkg::N_MIN;
    end else if (node_count_q > DEPTH_C) begin
      n_eff = DEPTH_C;
    end else begin
      n_eff = node_count_q;
    end
  end

  assign total      = LW'(n_eff - tpe_pkg::N_MIN);
  assign total_zero = (total == '0);

  // ---------------------------------------------------------------------------
  // Shared conditions
  // ---------------------------------------------------------------------------
  // Endpoints past the store are dropped (only possible when MAX_NODES < 64).
  assign a_ok     = ({1'b0, a_q} < DEPTH_C);
  assign b_ok     = ({1'b0, b_q} < DEPTH_C);
  assign nb_ok    = ({1'b0, nb_q} < DEPTH_C);
  assign rd_nb_ok = ({1'b0, st_rdata.nxor} < DEPTH_C);

  // A live leaf: not removed and degree exactly one. Unwritten entries read 0.
  assign chk_leaf  = chk_vld_q && !st_rdata.removed &&
                     (st_rdata.deg == tpe_pkg::DEG_W'(1));
  assign scan_more = (scan_q < n_eff);
  assign emit_go   = !out_vld_q || !out_stall_i;
  assign step_nx   = step_q + LW'(1);
  assign step_last = (step_nx == total);

  // Saturating decrement of the neighbour degree
  assign nb_deg_dec = (st_rdata.deg == '0) ? '0 : st_rdata.deg - tpe_pkg::DEG_W'(1);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tpe_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = tpe_pkg::S_LD_RA;
        end
      end
      tpe_pkg::S_LD_RA: begin
        if (a_ok && b_ok) begin
          state_d = tpe_pkg::S_LD_WA;
        end else if (!last_q) begin
          state_d = tpe_pkg::S_IDLE;
        end else if (total_zero) begin
          state_d = tpe_pkg::S_DONE;
        end else begin
          state_d = tpe_pkg::S_STEP;
        end
      end
      tpe_pkg::S_LD_WA: state_d = tpe_pkg::S_LD_RB;
      tpe_pkg::S_LD_RB: state_d = tpe_pkg::S_LD_WB;
      tpe_pkg::S_LD_WB: begin
        if (!last_q) begin
          state_d = tpe_pkg::S_IDLE;
        end else if (total_zero) begin
          state_d = tpe_pkg::S_DONE;
        end else begin
          state_d = tpe_pkg::S_STEP;
        end
      end
      tpe_pkg::S_STEP: begin
        state_d = sc_vld_q ? tpe_pkg::S_RD_LEAF : tpe_pkg::S_SCAN;
      end
      tpe_pkg::S_SCAN: begin
        if (chk_leaf) begin
          state_d = tpe_pkg::S_RD_LEAF;
        end else if (!scan_more) begin
          state_d = tpe_pkg::S_EMIT;     // no live leaf: emit 0
        end
      end
      tpe_pkg::S_RD_LEAF: state_d = tpe_pkg::S_WR_LEAF;
      tpe_pkg::S_WR_LEAF: begin
        state_d = rd_nb_ok ? tpe_pkg::S_RD_NB : tpe_pkg::S_EMIT;
      end
      tpe_pkg::S_RD_NB:   state_d = tpe_pkg::S_WR_NB;
      tpe_pkg::S_WR_NB:   state_d = tpe_pkg::S_EMIT;
      tpe_pkg::S_EMIT: begin
        if (emit_go) begin
          state_d = step_last ? tpe_pkg::S_DONE : tpe_pkg::S_STEP;
        end
      end
      tpe_pkg::S_DONE:    state_d = tpe_pkg::S_IDLE;
      default:            state_d = tpe_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and store control
  // ---------------------------------------------------------------------------
  always_comb begin
    a_d        = a_q;
    b_d        = b_q;
    last_d     = last_q;
    step_d     = step_q;
    ptr_d      = ptr_q;
    scan_d     = scan_q;
    chk_d      = chk_q;
    chk_vld_d  = chk_vld_q;
    leaf_d     = leaf_q;
    nb_d       = nb_q;
    sc_vld_d   = sc_vld_q;
    sc_d       = sc_q;
    code_d     = code_q;
    out_last_d = out_last_q;
    out_vld_d  = out_vld_q && out_stall_i;

    st_we    = 1'b0;
    st_clr   = 1'b0;
    st_waddr = '0;
    st_raddr = '0;
    st_wdata = st_rdata;

    unique case (state_q)
      tpe_pkg::S_IDLE: begin
        if (in_valid_i) begin
          a_d    = end_a_i;
          b_d    = end_b_i;
          last_d = last_edge_i;
        end
      end
      tpe_pkg::S_LD_RA: st_raddr = a_q[AW-1:0];
      tpe_pkg::S_LD_WA: begin
        st_we         = 1'b1;
        st_waddr      = a_q[AW-1:0];
        st_wdata.deg  = st_rdata.deg + tpe_pkg::DEG_W'(1);
        st_wdata.nxor = st_rdata.nxor ^ b_q;
      end
      // Read of b follows the write of a, so a self loop sees the first update.
      tpe_pkg::S_LD_RB: st_raddr = b_q[AW-1:0];
      tpe_pkg::S_LD_WB: begin
        st_we         = 1'b1;
        st_waddr      = b_q[AW-1:0];
        st_wdata.deg  = st_rdata.deg + tpe_pkg::DEG_W'(1);
        st_wdata.nxor = st_rdata.nxor ^ a_q;
      end
      tpe_pkg::S_STEP: begin
        if (sc_vld_q) begin
          leaf_d   = sc_q;
          sc_vld_d = 1'b0;
        end else begin
          scan_d    = ptr_q;
          chk_vld_d = 1'b0;
        end
      end
      // Pipelined scan: issue one address per cycle, test the one read before.
      tpe_pkg::S_SCAN: begin
        if (chk_leaf) begin
          leaf_d = chk_q;
          ptr_d  = {1'b0, chk_q};
        end else if (scan_more) begin
          st_raddr  = scan_q[AW-1:0];
          chk_d     = scan_q[LW-1:0];
          chk_vld_d = 1'b1;
          scan_d    = scan_q + CW'(1);
        end else begin
          nb_d  = '0;
          ptr_d = n_eff;
        end
      end
      tpe_pkg::S_RD_LEAF: st_raddr = leaf_q[AW-1:0];
      tpe_pkg::S_WR_LEAF: begin
        st_we            = 1'b1;
        st_waddr         = leaf_q[AW-1:0];
        st_wdata.removed = 1'b1;
        nb_d             = st_rdata.nxor;   // the single live neighbour
      end
      tpe_pkg::S_RD_NB: st_raddr = nb_q[AW-1:0];
      tpe_pkg::S_WR_NB: begin
        st_we         = 1'b1;
        st_waddr      = nb_q[AW-1:0];
        st_wdata.deg  = nb_deg_dec;
        st_wdata.nxor = st_rdata.nxor ^ leaf_q;
        // Everything below the pointer is a non-leaf, so a neighbour that
        // turns into a leaf below it is the next smallest leaf.
        if ((nb_deg_dec == tpe_pkg::DEG_W'(1)) && !st_rdata.removed &&
            ({1'b0, nb_q} < ptr_q) && nb_ok) begin
          sc_vld_d = 1'b1;
          sc_d     = nb_q;
        end
      end
      tpe_pkg::S_EMIT: begin
        if (emit_go) begin
          out_vld_d  = 1'b1;
          code_d     = nb_q;
          out_last_d = step_last;
          step_d     = step_nx;
        end
      end
      tpe_pkg::S_DONE: begin
        st_clr   = 1'b1;
        ptr_d    = '0;
        sc_vld_d = 1'b0;
        step_d   = '0;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tpe_pkg::S_IDLE;
      node_count_q <= tpe_pkg::N_MIN;
      step_q       <= '0;
      ptr_q        <= '0;
      scan_q       <= '0;
      chk_vld_q    <= 1'b0;
      sc_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      ptr_q     <= ptr_d;
      scan_q    <= scan_d;
      chk_vld_q <= chk_vld_d;
      sc_vld_q  <= sc_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_wr) begin
        node_count_q <= pwdata[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    last_q     <= last_d;
    chk_q      <= chk_d;
    leaf_q     <= leaf_d;
    nb_q       <= nb_d;
    sc_q       <= sc_d;
    code_q     <= code_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o  = (state_q != tpe_pkg::S_IDLE);
  assign out_valid_o = out_vld_q;
  assign code_node_o = code_q;
  assign last_code_o = out_last_q;

endmodule
